[rtl/core/frcu_pkg.sv]
// Shared widths, constants and the result kind codes for the entry re-key
// and read coalescer. No dependencies.
package frcu_pkg;

    localparam int OFF_W   = 48;   // offset and byte count fields
    localparam int LEN_W   = 32;   // entry length and longest length
    localparam int KEY_W   = 40;   // key fields on the result channel
    localparam int CHUNK_W = 17;   // chunk size register

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4096);

    typedef enum logic [1:0] {
        KIND_PLACE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

endpackage

[rtl/core/frcu_if.sv]
// Channel interfaces for the coalescer: configuration writes, index entries
// in, results out. Depends on frcu_pkg.
interface frcu_cfg_if import frcu_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CHUNK_W-1:0] chunk_entries;

    modport source (output valid, output chunk_entries, input ready);
    modport sink   (input valid, input chunk_entries, output ready);
endinterface

interface frcu_in_if import frcu_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] src_offset;
    logic [LEN_W-1:0] entry_length;
    logic             keep;
    logic             final_entry;

    modport source (output valid, output src_offset, output entry_length,
                    output keep, output final_entry, input ready);
    modport sink   (input valid, input src_offset, input entry_length,
                    input keep, input final_entry, output ready);
endinterface

interface frcu_out_if import frcu_pkg::*;;
    logic             valid;
    logic             ready;
    t_kind            kind;
    logic [KEY_W-1:0] sub_key;
    logic [KEY_W-1:0] orig_key;
    logic [OFF_W-1:0] dest_offset;
    logic [OFF_W-1:0] read_from;
    logic [OFF_W-1:0] byte_count;
    logic [LEN_W-1:0] longest;
    logic             last_result;

    modport source (output valid, output kind, output sub_key, output orig_key,
                    output dest_offset, output read_from, output byte_count,
                    output longest, output last_result, input ready);
    modport sink   (input valid, input kind, input sub_key, input orig_key,
                    input dest_offset, input read_from, input byte_count,
                    input longest, input last_result, output ready);
endinterface

[rtl/core/filtered_entry_rekey_and_read_coalescer_unit.sv]
// Entry re-key and read coalescer: top level, whole datapath in one pass.
// Depends on frcu_pkg and the channel interfaces in frcu_if.sv.
//
//  channel | dir | transfer when       | carries
//  --------+-----+---------------------+--------------------------------------
//  i_cfg   | in  | valid (ready tied)  | chunk_entries
//  i_in    | in  | valid & ready       | src_offset, entry_length, keep, final
//  o_out   | out | valid & ready       | kind, keys, offsets, counts, last
//
// When an entry is taken, all stream state updates at that edge and its
// results (up to four) land in a slot bundle. The bundle drains one result
// per cycle into the output register while o_out is not stalled, so a
// one-result entry runs at one per cycle; an entry with more results holds
// off the next. i_in.ready is high only with the bundle empty or its last
// result leaving. Reset is synchronous and clears all stream state and queues.
module filtered_entry_rekey_and_read_coalescer_unit import frcu_pkg::*; #(
    parameter int KEY_BITS    = 40,
    parameter int OFFSET_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frcu_cfg_if.sink    i_cfg,
    frcu_in_if.sink     i_in,
    frcu_out_if.source  o_out
);

    localparam int OW = OFFSET_BITS;
    localparam int KB = KEY_BITS;
    localparam int XW = (OW > OFF_W) ? OW : OFF_W;
    localparam logic [OW-1:0] OFF_MAX = '1;

    localparam logic [1:0] SLOT_PRE  = 2'd0;   // run that the entry cannot join
    localparam logic [1:0] SLOT_PLC  = 2'd1;   // placement
    localparam logic [1:0] SLOT_POST = 2'd2;   // chunk boundary or final flush
    localparam logic [1:0] SLOT_SUM  = 2'd3;   // end summary

    function automatic logic [OW-1:0] sat_add(input logic [OW-1:0] a,
                                              input logic [OW-1:0] b);
        logic [OW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OW] ? OFF_MAX : s[OW-1:0];
    endfunction

    // stream state
    logic [CHUNK_W-1:0] r_chunk_entries;
    logic [KB-1:0]      r_src_cnt;
    logic [KB-1:0]      r_kept_cnt;
    logic [OW-1:0]      r_next_dest;
    logic               r_run_open;
    logic [OW-1:0]      r_run_start;
    logic [OW-1:0]      r_run_end;
    logic [OW-1:0]      r_run_wanted;
    logic [CHUNK_W-1:0] r_chunk_fill;
    logic [LEN_W-1:0]   r_max_len;

    // result bundle
    logic [3:0]         r_mask;
    logic [OW-1:0]      r_pre_start;
    logic [OW-1:0]      r_pre_span;
    logic [LEN_W-1:0]   r_pre_longest;
    logic [KB-1:0]      r_plc_sub;
    logic [KB-1:0]      r_plc_orig;
    logic [OW-1:0]      r_plc_dest;
    logic [OW-1:0]      r_plc_from;
    logic [LEN_W-1:0]   r_plc_len;
    logic [OW-1:0]      r_post_start;
    logic [OW-1:0]      r_post_span;
    logic [KB-1:0]      r_sum_kept;
    logic [KB-1:0]      r_sum_src;
    logic [OW-1:0]      r_sum_total;
    logic [LEN_W-1:0]   r_longest;

    // output register
    logic               r_out_valid;
    t_kind              r_o_kind;
    logic [KEY_W-1:0]   r_o_sub;
    logic [KEY_W-1:0]   r_o_orig;
    logic [OFF_W-1:0]   r_o_dest;
    logic [OFF_W-1:0]   r_o_from;
    logic [OFF_W-1:0]   r_o_count;
    logic [LEN_W-1:0]   r_o_longest;
    logic               r_o_last;

    // entry datapath
    logic [XW-1:0]      off_x;
    logic [OW-1:0]      off_c;
    logic [OW-1:0]      len_c;
    logic [OW-1:0]      end_c;
    logic [CHUNK_W-1:0] lim;
    logic [OW-1:0]      wanted_j;
    logic [OW:0]        cap;
    logic [OW-1:0]      far;
    logic [OW-1:0]      far_span;
    logic               join_run;
    logic               kept;
    logic               fin;
    logic               pre_flush;
    logic               run_open_mid;
    logic [OW-1:0]      run_start_mid;
    logic [OW-1:0]      run_end_mid;
    logic [OW-1:0]      run_wanted_mid;
    logic [LEN_W-1:0]   n_max_len;
    logic [OW-1:0]      n_next_dest;
    logic [KB-1:0]      n_kept_cnt;
    logic [KB-1:0]      n_src_cnt;
    logic [CHUNK_W-1:0] fill_inc;
    logic               chunk_hit;
    logic [CHUNK_W-1:0] n_chunk_fill;
    logic               post_flush;
    logic [3:0]         n_mask;
    logic               in_xfer;

    // drain side
    logic               load_out;
    logic [1:0]         sel;
    logic [3:0]         sel_bit;

    assign off_x = XW'(i_in.src_offset);
    assign off_c = (off_x > XW'(OFF_MAX)) ? OFF_MAX : off_x[OW-1:0];
    assign len_c = OW'(i_in.entry_length);
    assign end_c = sat_add(off_c, len_c);
    assign lim   = (r_chunk_entries == '0) ? CHUNK_W'(1) : r_chunk_entries;
    assign kept  = i_in.keep;
    assign fin   = i_in.final_entry;

    // join test against the open run
    assign wanted_j = sat_add(r_run_wanted, len_c);
    assign cap      = {wanted_j, 1'b0};
    assign far      = (end_c > r_run_end) ? end_c : r_run_end;
    assign far_span = far - r_run_start;
    assign join_run = (off_c >= r_run_start) && ({1'b0, far_span} <= cap);

    assign pre_flush = kept && r_run_open && !join_run;

    always_comb begin
        run_open_mid   = r_run_open;
        run_start_mid  = r_run_start;
        run_end_mid    = r_run_end;
        run_wanted_mid = r_run_wanted;
        if (kept) begin
            run_open_mid = 1'b1;
            if (r_run_open && join_run) begin
                run_end_mid    = far;
                run_wanted_mid = wanted_j;
            end else begin
                run_start_mid  = off_c;
                run_end_mid    = end_c;
                run_wanted_mid = len_c;
            end
        end
    end

    assign n_max_len    = (kept && (i_in.entry_length > r_max_len)) ?
                          i_in.entry_length : r_max_len;
    assign n_next_dest  = kept ? sat_add(r_next_dest, len_c) : r_next_dest;
    assign n_kept_cnt   = kept ? r_kept_cnt + KB'(1) : r_kept_cnt;
    assign n_src_cnt    = r_src_cnt + KB'(1);
    assign fill_inc     = r_chunk_fill + CHUNK_W'(1);
    assign chunk_hit    = kept && (fill_inc >= lim);
    assign n_chunk_fill = !kept ? r_chunk_fill : (chunk_hit ? '0 : fill_inc);
    assign post_flush   = run_open_mid && (chunk_hit || fin);
    assign n_mask       = {fin, post_flush, kept, pre_flush};

    // drain: lowest occupied slot goes next
    always_comb begin
        if (r_mask[0]) begin
            sel = SLOT_PRE;
        end else if (r_mask[1]) begin
            sel = SLOT_PLC;
        end else if (r_mask[2]) begin
            sel = SLOT_POST;
        end else begin
            sel = SLOT_SUM;
        end
        sel_bit = 4'b0001 << sel;
    end

    assign load_out = (r_mask != 4'b0000) && (!r_out_valid || o_out.ready);
    assign i_in.ready = (r_mask == 4'b0000) || ($onehot(r_mask) && load_out);
    assign in_xfer  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_entries <= CHUNK_RESET;
        end else if (i_cfg.valid) begin
            r_chunk_entries <= i_cfg.chunk_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cnt    <= '0;
            r_kept_cnt   <= '0;
            r_next_dest  <= '0;
            r_run_open   <= 1'b0;
            r_run_start  <= '0;
            r_run_end    <= '0;
            r_run_wanted <= '0;
            r_chunk_fill <= '0;
            r_max_len    <= '0;
        end else if (in_xfer) begin
            if (fin) begin
                // end of stream: start the next one from scratch
                r_src_cnt    <= '0;
                r_kept_cnt   <= '0;
                r_next_dest  <= '0;
                r_run_open   <= 1'b0;
                r_run_start  <= '0;
                r_run_end    <= '0;
                r_run_wanted <= '0;
                r_chunk_fill <= '0;
                r_max_len    <= '0;
            end else begin
                r_src_cnt    <= n_src_cnt;
                r_kept_cnt   <= n_kept_cnt;
                r_next_dest  <= n_next_dest;
                r_run_open   <= run_open_mid && !post_flush;
                r_run_start  <= run_start_mid;
                r_run_end    <= run_end_mid;
                r_run_wanted <= run_wanted_mid;
                r_chunk_fill <= n_chunk_fill;
                r_max_len    <= n_max_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 4'b0000;
        end else if (in_xfer) begin
            r_mask <= n_mask;
        end else if (load_out) begin
            r_mask <= r_mask & ~sel_bit;
        end
        if (in_xfer) begin
            r_pre_start   <= r_run_start;
            r_pre_span    <= r_run_end - r_run_start;
            r_pre_longest <= r_max_len;
            r_plc_sub     <= r_kept_cnt;
            r_plc_orig    <= r_src_cnt;
            r_plc_dest    <= r_next_dest;
            r_plc_from    <= off_c;
            r_plc_len     <= i_in.entry_length;
            r_post_start  <= run_start_mid;
            r_post_span   <= run_end_mid - run_start_mid;
            r_sum_kept    <= n_kept_cnt;
            r_sum_src     <= n_src_cnt;
            r_sum_total   <= n_next_dest;
            r_longest     <= n_max_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_o_last <= (r_mask & ~sel_bit) == 4'b0000;
            case (sel)
                SLOT_PRE: begin
                    r_o_kind    <= KIND_READ;
                    r_o_sub     <= '0;
                    r_o_orig    <= '0;
                    r_o_dest    <= '0;
                    r_o_from    <= OFF_W'(r_pre_start);
                    r_o_count   <= OFF_W'(r_pre_span);
                    r_o_longest <= r_pre_longest;
                end
                SLOT_PLC: begin
                    r_o_kind    <= KIND_PLACE;
                    r_o_sub     <= KEY_W'(r_plc_sub);
                    r_o_orig    <= KEY_W'(r_plc_orig);
                    r_o_dest    <= OFF_W'(r_plc_dest);
                    r_o_from    <= OFF_W'(r_plc_from);
                    r_o_count   <= OFF_W'(r_plc_len);
                    r_o_longest <= r_longest;
                end
                SLOT_POST: begin
                    r_o_kind    <= KIND_READ;
                    r_o_sub     <= '0;
                    r_o_orig    <= '0;
                    r_o_dest    <= '0;
                    r_o_from    <= OFF_W'(r_post_start);
                    r_o_count   <= OFF_W'(r_post_span);
                    r_o_longest <= r_longest;
                end
                default: begin
                    r_o_kind    <= KIND_SUMMARY;
                    r_o_sub     <= KEY_W'(r_sum_kept);
                    r_o_orig    <= KEY_W'(r_sum_src);
                    r_o_dest    <= '0;
                    r_o_from    <= '0;
                    r_o_count   <= OFF_W'(r_sum_total);
                    r_o_longest <= r_longest;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_o_kind;
    assign o_out.sub_key     = r_o_sub;
    assign o_out.orig_key    = r_o_orig;
    assign o_out.dest_offset = r_o_dest;
    assign o_out.read_from   = r_o_from;
    assign o_out.byte_count  = r_o_count;
    assign o_out.longest     = r_o_longest;
    assign o_out.last_result = r_o_last;

    // a new entry is only taken once the bundle is down to its last result
    a_ready_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> $onehot0(r_mask))
        else $error("entry taken while bundle holds several results");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_SUMMARY)) |-> o_out.last_result)
        else $error("summary is not the last result of its entry");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && fin) |=> ((r_src_cnt == '0) && !r_run_open &&
                              (r_next_dest == '0)))
        else $error("stream state not cleared after final entry");

endmodule
